@@ rtl/core/cftp_pkg.sv @@
package cftp_pkg;

    // field and datapath widths
    localparam int COORD_W   = 24;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int DEN_W     = PROD_W + 2;
    localparam int NUM_W     = 76;
    localparam int REG_W     = 32;
    localparam int QUO_BITS  = 41;
    localparam int QUO_W     = QUO_BITS + 1;
    localparam int SQ_STEPS  = 32;
    localparam int DIV_LAT   = QUO_BITS + 3;
    localparam int SQ_LAT    = SQ_STEPS + 1;
    localparam int CFG_IDX_W = 1;

    // defaults for the top level parameters
    localparam int FRAC_BITS_DEF = 8;
    localparam int REGION_EDGE   = 1000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_X_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DEGEN    = 3'd1,
        ST_PARALLEL = 3'd2,
        ST_ZERO_RAD = 3'd3,
        ST_OUTSIDE  = 3'd4
    } t_status;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_a_x;
        logic signed [COORD_W-1:0] point_a_z;
        logic signed [COORD_W-1:0] point_b_x;
        logic signed [COORD_W-1:0] point_b_z;
        logic signed [COORD_W-1:0] point_c_x;
        logic signed [COORD_W-1:0] point_c_z;
    } t_in;

    typedef struct packed {
        logic signed [REG_W-1:0] center_x;
        logic signed [REG_W-1:0] center_y;
        logic        [REG_W-1:0] radius;
        logic        [2:0]       status;
    } t_out;

endpackage

@@ rtl/core/cftp_rdiv.sv @@
module cftp_rdiv (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [cftp_pkg::NUM_W-1:0]   i_num,
    input  logic signed [cftp_pkg::DEN_W-1:0]   i_den,
    output logic signed [cftp_pkg::QUO_W-1:0]   o_quo
);
    localparam int NW = cftp_pkg::NUM_W;
    localparam int DW = cftp_pkg::DEN_W;
    localparam int AW = NW + 1;
    localparam int MW = DW + 1;
    localparam int QB = cftp_pkg::QUO_BITS;
    localparam logic [QB-1:0] CLAMP = QB'(1) << (QB - 1);

    logic [NW-1:0] n_mag;
    logic [DW-1:0] d_mag;

    logic [AW-1:0] r_a;
    logic [MW-1:0] r_dm;
    logic          r_neg;

    logic [AW-1:0] r_rem [0:QB];
    logic [QB-1:0] r_q   [0:QB];
    logic [MW-1:0] r_dmp [0:QB];
    logic          r_ng  [0:QB];
    logic          r_ov  [0:QB];

    logic [QB-1:0]        q_mag;
    logic signed [QB:0]   r_quo;

    // take magnitudes, fold the half-divisor in for rounding
    always_comb begin
        n_mag = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
        d_mag = i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a   <= {n_mag, 1'b0} + AW'(d_mag);
            r_dm  <= {d_mag, 1'b0};
            r_neg <= i_num[NW-1] ^ i_den[DW-1];
        end
    end

    // flag quotients too large for the kept bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= r_a;
            r_q[0]   <= '0;
            r_dmp[0] <= r_dm;
            r_ng[0]  <= r_neg;
            r_ov[0]  <= (r_a >> QB) >= AW'(r_dm);
        end
    end

    // one restoring step per stage, most significant quotient bit first
    for (genvar s = 1; s <= QB; s++) begin : g_step
        localparam int K = QB - s;
        logic          take;
        logic [AW-1:0] n_rem;
        always_comb begin
            take  = (r_rem[s-1] >> K) >= AW'(r_dmp[s-1]);
            n_rem = take ? r_rem[s-1] - (AW'(r_dmp[s-1]) << K) : r_rem[s-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_q[s]   <= r_q[s-1] | (QB'(take) << K);
                r_dmp[s] <= r_dmp[s-1];
                r_ng[s]  <= r_ng[s-1];
                r_ov[s]  <= r_ov[s-1];
            end
        end
    end

    // clamp and restore the sign
    assign q_mag = (r_ov[QB] || r_q[QB] > CLAMP) ? CLAMP : r_q[QB];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo <= r_ng[QB] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
        end
    end

    assign o_quo = r_quo;
endmodule

@@ rtl/core/cftp_isqrt.sv @@
module cftp_isqrt (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [2*cftp_pkg::REG_W-1:0]     i_x,
    output logic [cftp_pkg::REG_W-1:0]       o_root
);
    localparam int N  = cftp_pkg::SQ_STEPS;
    localparam int XW = 2 * cftp_pkg::REG_W;
    localparam int RW = cftp_pkg::REG_W;

    logic [XW-1:0] r_x   [0:N-1];
    logic [XW-1:0] r_res [0:N-1];
    logic [RW:0]   root;
    logic [RW-1:0] r_root;

    // one result bit per stage
    for (genvar j = 0; j < N; j++) begin : g_step
        localparam logic [XW-1:0] BIT = XW'(1) << (XW - 2 - 2 * j);
        logic [XW-1:0] x_in;
        logic [XW-1:0] res_in;
        logic [XW-1:0] trial;
        if (j == 0) begin : g_first
            assign x_in   = i_x;
            assign res_in = '0;
        end else begin : g_next
            assign x_in   = r_x[j-1];
            assign res_in = r_res[j-1];
        end
        assign trial = res_in + BIT;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (x_in >= trial) begin
                    r_x[j]   <= x_in - trial;
                    r_res[j] <= (res_in >> 1) + BIT;
                end else begin
                    r_x[j]   <= x_in;
                    r_res[j] <= res_in >> 1;
                end
            end
        end
    end

    // round to nearest on the remainder, saturate
    assign root = (r_x[N-1] > r_res[N-1]) ? (RW+1)'(r_res[N-1]) + 1'b1
                                          : (RW+1)'(r_res[N-1]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_root <= root[RW] ? '1 : root[RW-1:0];
        end
    end

    assign o_root = r_root;
endmodule

@@ rtl/core/circle_from_three_points.sv @@
// Circumcircle of three hits, fully pipelined.
// Stages from item acceptance to result valid: six setup stages, a 44-stage
// rounding divider, three stages, a 33-stage square root, and the output register.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset (synchronous, active low) clears all valid bits and sets both region
// limits to -1000 in the Q.FRAC_BITS format.
module circle_from_three_points #(
    parameter int FRAC_BITS = cftp_pkg::FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  cftp_pkg::t_in                        i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output cftp_pkg::t_out                       o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [cftp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [cftp_pkg::REG_W-1:0]           i_cfg_data
);
    localparam int CW = cftp_pkg::COORD_W;
    localparam int DW = cftp_pkg::DIFF_W;
    localparam int PW = cftp_pkg::PROD_W;
    localparam int EW = cftp_pkg::DEN_W;
    localparam int NW = cftp_pkg::NUM_W;
    localparam int QW = cftp_pkg::QUO_W;
    localparam int RW = cftp_pkg::REG_W;
    localparam int HW = PW / 2;
    localparam int SW = CW + QW;
    localparam int NV = 10 + cftp_pkg::DIV_LAT + cftp_pkg::SQ_LAT;
    localparam int LIMIT_RST = -cftp_pkg::REGION_EDGE * (2 ** FRAC_BITS);
    localparam logic signed [SW-1:0] S_MAX = SW'(64'sd2147483647);
    localparam logic signed [SW-1:0] S_MIN = SW'(-64'sd2147483648);

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] az;
        logic                 deg;
        logic                 par;
    } t_side1;

    typedef struct packed {
        logic signed [RW-1:0] ox;
        logic signed [RW-1:0] oz;
        logic                 sat;
        cftp_pkg::t_status    status;
    } t_side2;

    function automatic logic signed [RW-1:0] sat32(input logic signed [SW-1:0] v);
        logic signed [RW-1:0] r;
        if (v > S_MAX) r = S_MAX[RW-1:0];
        else if (v < S_MIN) r = S_MIN[RW-1:0];
        else r = v[RW-1:0];
        return r;
    endfunction

    logic en;
    logic r_vld [0:NV-1];
    logic signed [RW-1:0] r_lim_x, r_lim_y;

    // stage 1
    logic signed [CW-1:0] r1_ax, r1_az;
    logic signed [DW-1:0] r1_bx, r1_bz, r1_cx, r1_cz;
    // stage 2
    t_side1 r2_sd;
    logic signed [DW-1:0] r2_bx, r2_bz, r2_cx, r2_cz;
    logic signed [PW-1:0] r2_bxcz, r2_bzcx, r2_bx2, r2_bz2, r2_cx2, r2_cz2;
    // stage 3
    t_side1 r3_sd;
    logic signed [DW-1:0] r3_bx, r3_bz, r3_cx, r3_cz;
    logic signed [EW-1:0] r3_den;
    logic        [PW-1:0] r3_sb, r3_sc;
    logic signed [PW:0]   cross_diff;
    // stage 4
    t_side1 r4_sd;
    logic signed [EW-1:0] r4_den;
    logic signed [PW:0]   r4_czsb_l, r4_czsb_h, r4_bzsc_l, r4_bzsc_h;
    logic signed [PW:0]   r4_bxsc_l, r4_bxsc_h, r4_cxsb_l, r4_cxsb_h;
    // stage 5
    t_side1 r5_sd;
    logic signed [EW-1:0] r5_den;
    logic signed [NW-1:0] r5_czsb, r5_bzsc, r5_bxsc, r5_cxsb;
    // stage 6
    t_side1 r6_sd;
    logic signed [EW-1:0] r6_den;
    logic signed [NW-1:0] r6_nx, r6_nz;
    // divider and its side line
    logic signed [QW-1:0] ux, uz;
    t_side1 r_sd1 [0:cftp_pkg::DIV_LAT-1];
    t_side1 sd1;
    // stage 7
    logic [QW-1:0] mx, mz;
    logic signed [RW-1:0] r7_ox, r7_oz;
    logic          [RW-1:0] r7_mx, r7_mz;
    logic r7_big, r7_zero, r7_deg, r7_par;
    // stage 8
    logic [2*RW-1:0] r8_px, r8_pz;
    logic signed [RW-1:0] r8_ox, r8_oz;
    logic r8_big;
    cftp_pkg::t_status r8_status;
    // stage 9
    t_side2 r9_sd;
    logic [2*RW-1:0] r9_rsq;
    logic [2*RW:0]   rsq;
    // square root and its side line
    logic [RW-1:0] root;
    t_side2 r_sd2 [0:cftp_pkg::SQ_LAT-1];
    t_side2 sd2;
    cftp_pkg::t_out r_out;

    // whole pipeline advances when the output slot is free
    assign en          = !r_vld[NV-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[NV-1];
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NV; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k < NV; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // region limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_x <= RW'(LIMIT_RST);
            r_lim_y <= RW'(LIMIT_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cftp_pkg::CFG_X_LIMIT: r_lim_x <= i_cfg_data;
                cftp_pkg::CFG_Y_LIMIT: r_lim_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: offsets from A
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ax <= i_in_data.point_a_x;
            r1_az <= i_in_data.point_a_z;
            r1_bx <= DW'(i_in_data.point_b_x) - DW'(i_in_data.point_a_x);
            r1_bz <= DW'(i_in_data.point_b_z) - DW'(i_in_data.point_a_z);
            r1_cx <= DW'(i_in_data.point_c_x) - DW'(i_in_data.point_a_x);
            r1_cz <= DW'(i_in_data.point_c_z) - DW'(i_in_data.point_a_z);
        end
    end

    // stage 2: cross and square products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_sd.ax  <= r1_ax;
            r2_sd.az  <= r1_az;
            r2_sd.deg <= (r1_bx == '0) || (r1_bz == '0) || (r1_cx == '0) || (r1_cz == '0);
            r2_sd.par <= 1'b0;
            r2_bx <= r1_bx;
            r2_bz <= r1_bz;
            r2_cx <= r1_cx;
            r2_cz <= r1_cz;
            r2_bxcz <= r1_bx * r1_cz;
            r2_bzcx <= r1_bz * r1_cx;
            r2_bx2  <= r1_bx * r1_bx;
            r2_bz2  <= r1_bz * r1_bz;
            r2_cx2  <= r1_cx * r1_cx;
            r2_cz2  <= r1_cz * r1_cz;
        end
    end

    // stage 3: denominator and squared lengths
    assign cross_diff = (PW+1)'(r2_bxcz) - (PW+1)'(r2_bzcx);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_sd  <= r2_sd;
            r3_bx  <= r2_bx;
            r3_bz  <= r2_bz;
            r3_cx  <= r2_cx;
            r3_cz  <= r2_cz;
            r3_den <= {cross_diff, 1'b0};
            r3_sb  <= PW'(r2_bx2 + r2_bz2);
            r3_sc  <= PW'(r2_cx2 + r2_cz2);
        end
    end

    // stage 4: numerator partial products on split lengths
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_sd.ax  <= r3_sd.ax;
            r4_sd.az  <= r3_sd.az;
            r4_sd.deg <= r3_sd.deg;
            r4_sd.par <= (r3_den == '0);
            r4_den    <= r3_den;
            r4_czsb_l <= r3_cz * $signed({1'b0, r3_sb[HW-1:0]});
            r4_czsb_h <= r3_cz * $signed({1'b0, r3_sb[PW-1:HW]});
            r4_bzsc_l <= r3_bz * $signed({1'b0, r3_sc[HW-1:0]});
            r4_bzsc_h <= r3_bz * $signed({1'b0, r3_sc[PW-1:HW]});
            r4_bxsc_l <= r3_bx * $signed({1'b0, r3_sc[HW-1:0]});
            r4_bxsc_h <= r3_bx * $signed({1'b0, r3_sc[PW-1:HW]});
            r4_cxsb_l <= r3_cx * $signed({1'b0, r3_sb[HW-1:0]});
            r4_cxsb_h <= r3_cx * $signed({1'b0, r3_sb[PW-1:HW]});
        end
    end

    // stage 5: join the partial products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_sd   <= r4_sd;
            r5_den  <= r4_den;
            r5_czsb <= (NW'(r4_czsb_h) <<< HW) + NW'(r4_czsb_l);
            r5_bzsc <= (NW'(r4_bzsc_h) <<< HW) + NW'(r4_bzsc_l);
            r5_bxsc <= (NW'(r4_bxsc_h) <<< HW) + NW'(r4_bxsc_l);
            r5_cxsb <= (NW'(r4_cxsb_h) <<< HW) + NW'(r4_cxsb_l);
        end
    end

    // stage 6: centre numerators
    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_sd  <= r5_sd;
            r6_den <= r5_den;
            r6_nx  <= r5_czsb - r5_bzsc;
            r6_nz  <= r5_bxsc - r5_cxsb;
        end
    end

    cftp_rdiv u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r6_nx),
        .i_den (r6_den),
        .o_quo (ux)
    );

    cftp_rdiv u_div_z (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r6_nz),
        .i_den (r6_den),
        .o_quo (uz)
    );

    // carry A and flags alongside the dividers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd1[0] <= r6_sd;
            for (int k = 1; k < cftp_pkg::DIV_LAT; k++) r_sd1[k] <= r_sd1[k-1];
        end
    end
    assign sd1 = r_sd1[cftp_pkg::DIV_LAT-1];

    // stage 7: centre, offset magnitudes
    assign mx = ux[QW-1] ? QW'(-ux) : QW'(ux);
    assign mz = uz[QW-1] ? QW'(-uz) : QW'(uz);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_ox   <= sat32(SW'(sd1.ax) + SW'(ux));
            r7_oz   <= sat32(SW'(sd1.az) + SW'(uz));
            r7_mx   <= mx[RW-1:0];
            r7_mz   <= mz[RW-1:0];
            r7_big  <= (|mx[QW-1:RW]) || (|mz[QW-1:RW]);
            r7_zero <= (ux == '0) && (uz == '0);
            r7_deg  <= sd1.deg;
            r7_par  <= sd1.par;
        end
    end

    // stage 8: squares and status
    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_px  <= r7_mx * r7_mx;
            r8_pz  <= r7_mz * r7_mz;
            r8_ox  <= r7_ox;
            r8_oz  <= r7_oz;
            r8_big <= r7_big;
            if (r7_deg) r8_status <= cftp_pkg::ST_DEGEN;
            else if (r7_par) r8_status <= cftp_pkg::ST_PARALLEL;
            else if (r7_zero) r8_status <= cftp_pkg::ST_ZERO_RAD;
            else if (r7_ox > r_lim_x || r7_oz > r_lim_y) r8_status <= cftp_pkg::ST_OUTSIDE;
            else r8_status <= cftp_pkg::ST_OK;
        end
    end

    // stage 9: squared radius
    assign rsq = (2*RW+1)'(r8_px) + (2*RW+1)'(r8_pz);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_rsq       <= rsq[2*RW-1:0];
            r9_sd.ox     <= r8_ox;
            r9_sd.oz     <= r8_oz;
            r9_sd.sat    <= r8_big || rsq[2*RW];
            r9_sd.status <= r8_status;
        end
    end

    cftp_isqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (r9_rsq),
        .o_root (root)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd2[0] <= r9_sd;
            for (int k = 1; k < cftp_pkg::SQ_LAT; k++) r_sd2[k] <= r_sd2[k-1];
        end
    end
    assign sd2 = r_sd2[cftp_pkg::SQ_LAT-1];

    // output register: pick fields by status
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.status <= 3'(sd2.status);
            case (sd2.status)
                cftp_pkg::ST_DEGEN, cftp_pkg::ST_PARALLEL: begin
                    r_out.center_x <= '0;
                    r_out.center_y <= '0;
                    r_out.radius   <= '0;
                end
                cftp_pkg::ST_ZERO_RAD: begin
                    r_out.center_x <= sd2.ox;
                    r_out.center_y <= sd2.oz;
                    r_out.radius   <= '0;
                end
                default: begin
                    r_out.center_x <= sd2.ox;
                    r_out.center_y <= sd2.oz;
                    r_out.radius   <= sd2.sat ? '1 : root;
                end
            endcase
        end
    end
endmodule

@@ bench/circle_from_three_points_tb.sv @@
module circle_from_three_points_tb;

    localparam int FRAC         = cftp_pkg::FRAC_BITS_DEF;
    localparam int PIPE_DRAIN   = 120;
    localparam int LONG_HOLD    = 400;
    localparam longint RAD_CLAMP = 64'sd1 << 40;

    logic   i_clk;
    logic   i_rst_n;
    logic   in_valid;
    logic   in_ready;
    cftp_pkg::t_in    in_data;
    logic   out_valid;
    logic   out_ready;
    cftp_pkg::t_out   out_data;
    logic   cfg_we;
    logic [cftp_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [cftp_pkg::REG_W-1:0]     cfg_data;

    // region limits as the predictor sees them
    longint x_limit;
    longint y_limit;

    cftp_pkg::t_in    hits_pending[$];
    cftp_pkg::t_out   circles_due[$];
    int     n_errors;
    int     n_taken;
    int     n_circles;
    int     status_seen[5];
    bit     taken_now;
    int     burst_left;
    int     gap_left;
    int     stall_left;
    int     hold_left;
    bit     hold_done;

    circle_from_three_points u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // quotient rounded to nearest, ties away from zero, clamped
    function automatic longint round_div(input logic signed [127:0] num, input longint den);
        logic [127:0] an;
        logic [127:0] ad;
        logic [127:0] q;
        longint mag;
        an = num < 0 ? -num : num;
        ad = den < 0 ? 128'(-den) : 128'(den);
        q = (2 * an + ad) / (2 * ad);
        mag = (q > 128'(RAD_CLAMP)) ? RAD_CLAMP : longint'(q);
        return ((num < 0) != (den < 0)) ? -mag : mag;
    endfunction

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // square root rounded to nearest, saturated to 32 bits
    function automatic logic [31:0] root_round(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        if (x > res) res = res + 1;
        return (res > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : res[31:0];
    endfunction

    function automatic cftp_pkg::t_out circumcircle(input cftp_pkg::t_in h);
        cftp_pkg::t_out r;
        longint ax, az, bx, bz, cx, cz, den, ux, uz, ox, oz, sb, sc;
        logic signed [127:0] w_bx, w_bz, w_cx, w_cz, w_sb, w_sc;
        logic [64:0] rsq;
        logic [63:0] mx, mz;
        r = '0;
        ax = h.point_a_x;
        az = h.point_a_z;
        bx = longint'(h.point_b_x) - ax;
        bz = longint'(h.point_b_z) - az;
        cx = longint'(h.point_c_x) - ax;
        cz = longint'(h.point_c_z) - az;
        if (bx == 0 || bz == 0 || cx == 0 || cz == 0) begin
            r.status = cftp_pkg::ST_DEGEN;
            return r;
        end
        den = 2 * (bx * cz - bz * cx);
        if (den == 0) begin
            r.status = cftp_pkg::ST_PARALLEL;
            return r;
        end
        sb = bx * bx + bz * bz;
        sc = cx * cx + cz * cz;
        w_bx = bx; w_bz = bz; w_cx = cx; w_cz = cz; w_sb = sb; w_sc = sc;
        ux = round_div(w_cz * w_sb - w_bz * w_sc, den);
        uz = round_div(w_bx * w_sc - w_cx * w_sb, den);
        ox = clip32(ax + ux);
        oz = clip32(az + uz);
        r.center_x = ox[31:0];
        r.center_y = oz[31:0];
        if (ux == 0 && uz == 0) begin
            r.status = cftp_pkg::ST_ZERO_RAD;
            return r;
        end
        mx = ux < 0 ? -ux : ux;
        mz = uz < 0 ? -uz : uz;
        if (mx > 64'hFFFF_FFFF || mz > 64'hFFFF_FFFF) begin
            r.radius = 32'hFFFF_FFFF;
        end else begin
            rsq = 65'(mx * mx) + 65'(mz * mz);
            r.radius = rsq[64] ? 32'hFFFF_FFFF : root_round(rsq[63:0]);
        end
        r.status = (ox > x_limit || oz > y_limit) ? cftp_pkg::ST_OUTSIDE : cftp_pkg::ST_OK;
        return r;
    endfunction

    function automatic logic signed [23:0] rnd_coord();
        return 24'($urandom());
    endfunction

    function automatic logic signed [23:0] near(input int v, input int spread);
        return 24'(v + $signed($urandom_range(2 * spread)) - spread);
    endfunction

    // mostly plausible triplets, with full-scale noise and degenerate shapes
    function automatic cftp_pkg::t_in random_triplet();
        cftp_pkg::t_in h;
        int  ax, az, dx, dz, k;
        h = {rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()};
        ax = $signed($urandom_range(200000)) - 100000;
        az = $signed($urandom_range(200000)) - 100000;
        case ($urandom_range(5))
            0: ;
            1: begin
                h.point_a_x = near(ax, 4); h.point_a_z = near(az, 4);
                h.point_b_x = near(ax, 4); h.point_b_z = near(az, 4);
                h.point_c_x = near(ax, 4); h.point_c_z = near(az, 4);
            end
            2: begin
                dx = $signed($urandom_range(2000)) - 1000;
                dz = $signed($urandom_range(2000)) - 1000;
                k = int'($urandom_range(3));
                h.point_a_x = 24'(ax); h.point_a_z = 24'(az);
                h.point_b_x = 24'(ax + dx); h.point_b_z = 24'(az + dz);
                h.point_c_x = 24'(ax + (k + 2) * dx + ($urandom_range(1) ? 0 : 1));
                h.point_c_z = 24'(az + (k + 2) * dz);
            end
            default: begin
                h.point_a_x = 24'(ax); h.point_a_z = 24'(az);
                h.point_b_x = near(ax, 30000); h.point_b_z = near(az, 30000);
                h.point_c_x = near(ax, 30000); h.point_c_z = near(az, 30000);
            end
        endcase
        return h;
    endfunction

    function automatic cftp_pkg::t_in triplet(input int ax, az, bx, bz, cx, cz);
        cftp_pkg::t_in h;
        h.point_a_x = 24'(ax); h.point_a_z = 24'(az);
        h.point_b_x = 24'(bx); h.point_b_z = 24'(bz);
        h.point_c_x = 24'(cx); h.point_c_z = 24'(cz);
        return h;
    endfunction

    // append one item to the sender's queue
    function automatic void queue_hit(input cftp_pkg::t_in h);
        hits_pending.insert(hits_pending.size(), h);
    endfunction

    // write one limit register at a falling edge
    task automatic write_limit(input logic [cftp_pkg::CFG_IDX_W-1:0] idx,
                               input logic [cftp_pkg::REG_W-1:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == cftp_pkg::CFG_X_LIMIT) x_limit = longint'($signed(val));
        else y_limit = longint'($signed(val));
    endtask

    task automatic drain();
        while (hits_pending.size() != 0 || in_valid || circles_due.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    // record acceptances, predict, and check results
    always @(posedge i_clk) begin
        cftp_pkg::t_out want;
        taken_now <= i_rst_n && in_valid && in_ready;
        if (i_rst_n) begin
            if (in_valid && in_ready) begin
                circles_due.insert(circles_due.size(), circumcircle(in_data));
                n_taken <= n_taken + 1;
            end
            if (out_valid && out_ready) begin
                n_circles <= n_circles + 1;
                if (circles_due.size() == 0) begin
                    $error("result with nothing expected");
                    n_errors = n_errors + 1;
                end else begin
                    want = circles_due.pop_front();
                    if (out_data.status <= 3'(cftp_pkg::ST_OUTSIDE))
                        status_seen[out_data.status]++;
                    if (out_data.center_x !== want.center_x) begin
                        $error("center_x expected %0d got %0d", want.center_x, out_data.center_x);
                        n_errors = n_errors + 1;
                    end
                    if (out_data.center_y !== want.center_y) begin
                        $error("center_y expected %0d got %0d", want.center_y, out_data.center_y);
                        n_errors = n_errors + 1;
                    end
                    if (out_data.radius !== want.radius) begin
                        $error("radius expected %0d got %0d", want.radius, out_data.radius);
                        n_errors = n_errors + 1;
                    end
                    if (out_data.status !== want.status) begin
                        $error("status expected %0d got %0d", want.status, out_data.status);
                        n_errors = n_errors + 1;
                    end
                end
            end
        end
    end

    // offer items in bursts with random gaps
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_valid || taken_now)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else if (hits_pending.size() != 0) begin
                in_data <= hits_pending.pop_front();
                in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(40, 1);
                    gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // stall the result side, with one long hold-off to back up the pipeline
    always @(negedge i_clk) begin
        if (!hold_done && n_taken >= 300) begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(9) == 0) stall_left <= $urandom_range(8, 1);
            else if ($urandom_range(49) == 0) stall_left <= 0;
        end
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        logic [cftp_pkg::REG_W-1:0] xs[5];
        logic [cftp_pkg::REG_W-1:0] ys[5];
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = cftp_pkg::CFG_X_LIMIT;
        cfg_data = '0;
        n_errors = 0;
        n_taken = 0;
        n_circles = 0;
        taken_now = 1'b0;
        burst_left = 0;
        gap_left = 0;
        stall_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        x_limit = -longint'(cftp_pkg::REGION_EDGE) <<< FRAC;
        y_limit = -longint'(cftp_pkg::REGION_EDGE) <<< FRAC;
        i_rst_n = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // extremes, each degenerate pair, collinear and near-collinear shapes
        queue_hit(triplet(-8388608, -8388608, 8388607, 8388607, 8388607, -8388607));
        queue_hit(triplet(8388607, 8388607, -8388608, -8388608, -8388608, 8388606));
        queue_hit(triplet(-8388608, 8388607, 8388607, -8388608, 8388606, 8388606));
        queue_hit(triplet(8388607, -8388608, -8388608, 8388607, 0, 0));
        queue_hit(triplet(0, 0, 0, 5, 3, 7));
        queue_hit(triplet(0, 0, 5, 0, 3, 7));
        queue_hit(triplet(0, 0, 3, 7, 0, 5));
        queue_hit(triplet(0, 0, 3, 7, 5, 0));
        queue_hit(triplet(10, 10, 10, 10, 10, 10));
        queue_hit(triplet(0, 0, 1, 1, 2, 2));
        queue_hit(triplet(-5, 3, -3, 7, 3, 19));
        queue_hit(triplet(0, 0, 1000, 1000, 2001, 2000));
        queue_hit(triplet(-8388608, -8388608, 0, 1, 8388607, 8388607));
        queue_hit(triplet(0, 0, 1, 1, 1, -1));
        queue_hit(triplet(0, 0, 1, 2, -2, 1));
        queue_hit(triplet(0, 0, 1, -1, -1, -2));
        queue_hit(triplet(-256000, -256000, -255744, -255744, -255744, -256256));
        queue_hit(triplet(-512000, -600000, -500000, -590000, -520000, -580000));
        queue_hit(triplet(100, -200, 300, 50, -80, 400));
        queue_hit(triplet(-1, -1, 1, 1, -1, 2));
        drain();

        // limit settings: extremes, zero, the reset value for x and random
        xs = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFC_1800, $urandom()};
        ys = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, $urandom()};
        for (int p = 0; p < 5; p++) begin
            write_limit(cftp_pkg::CFG_X_LIMIT, xs[p]);
            write_limit(cftp_pkg::CFG_Y_LIMIT, ys[p]);
            for (int i = 0; i < 130; i++) queue_hit(random_triplet());
            drain();
        end

        $display("covered %0d triplets, %0d circles under six limit settings", n_taken, n_circles);
        $display("statuses ok/degenerate/parallel/zero/outside: %0d/%0d/%0d/%0d/%0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
        if (n_errors == 0 && circles_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
